/* sv/sorted_key_table_macros.svh */
// ----------------------------------------------------------------------------
// sorted_key_table_macros
// Assertion macros for the sorted key table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// check a property at every edge out of reset
`define SKT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies a property at the next edge
`define SKT_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* sv/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// Request codes, status codes and entry types of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int REQ_W    = 3;
  localparam int STATUS_W = 3;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CUR_RESET = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CUR_NEXT  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_END     = 3'd4;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     handle;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    entry_t              entry;
  } result_t;

endpackage

/* sv/sorted_key_table.sv */
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted table of signed keys and record handles with insert, remove,
// search and an in-order cursor, run by a sequencer over one entry memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | req_type, key, record_handle
//  out_    | output    | out_valid/out_stall | status, key_out, handle_out, entry_count
//
//  Insert, remove and search scan the entries in order until one is not below
//  the key; a successful insert or remove then shifts the entries from that
//  place on; the entry memory takes one read and one write per cycle.
//  One item at a time; in_stall is high from accept until the result loads
//  into the output register (held under out_stall); reset clears only the
//  state, count, cursor and output valid.
// ----------------------------------------------------------------------------
`include "sorted_key_table_macros.svh"

module sorted_key_table #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [skt_pkg::REQ_W-1:0]            in_req_type,
  input  logic signed [skt_pkg::KEY_W-1:0]     in_key,
  input  logic [skt_pkg::HANDLE_W-1:0]         in_record_handle,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [skt_pkg::STATUS_W-1:0]         out_status,
  output logic signed [skt_pkg::KEY_W-1:0]     out_key_out,
  output logic [skt_pkg::HANDLE_W-1:0]         out_handle_out,
  output logic [skt_pkg::COUNT_W-1:0]          out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_SHRD = 6'b001000,
    S_SHWR = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [skt_pkg::REQ_W-1:0]       op_r, op_nxt;
  logic signed [skt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [skt_pkg::HANDLE_W-1:0]    hdl_r, hdl_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic [CW-1:0]                   sh_r, sh_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [CW-1:0]                   cur_r, cur_nxt;
  skt_pkg::result_t                res_r, res_nxt;

  logic                            out_valid_r, out_valid_nxt;
  skt_pkg::result_t                out_res_r, out_res_nxt;
  logic [skt_pkg::COUNT_W-1:0]     out_cnt_r, out_cnt_nxt;

  skt_pkg::entry_t                 mem [CAPACITY];
  skt_pkg::entry_t                 rd_data_r;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [AW-1:0]                   mem_raddr;
  skt_pkg::entry_t                 mem_wdata;

  logic                            resolve;
  logic                            hit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    hdl_nxt       = hdl_r;
    idx_nxt       = idx_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = sh_r[AW-1:0];
    mem_wdata     = rd_data_r;
    mem_raddr     = idx_r[AW-1:0];
    resolve       = 1'b0;
    hit           = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_req_type;
          key_nxt = in_key;
          hdl_nxt = in_record_handle;
          res_nxt = '0;
          idx_nxt = '0;
          case (in_req_type)
            skt_pkg::REQ_INSERT, skt_pkg::REQ_REMOVE, skt_pkg::REQ_SEARCH: begin
              state_nxt = S_RD;
            end
            skt_pkg::REQ_CUR_RESET: begin
              cur_nxt   = '0;
              state_nxt = S_DONE;
            end
            skt_pkg::REQ_CUR_NEXT: begin
              if (cur_r < cnt_r) begin
                idx_nxt   = cur_r;
                state_nxt = S_RD;
              end else begin
                res_nxt.status = skt_pkg::ST_END;
                cur_nxt        = '0;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        if (op_r != skt_pkg::REQ_CUR_NEXT && idx_r == cnt_r) begin
          resolve = 1'b1;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (op_r == skt_pkg::REQ_CUR_NEXT) begin
          res_nxt.entry = rd_data_r;
          cur_nxt       = CW'(cur_r + 1'b1);
          state_nxt     = S_DONE;
        end else if (rd_data_r.key < key_r) begin
          idx_nxt   = CW'(idx_r + 1'b1);
          state_nxt = S_RD;
        end else begin
          resolve = 1'b1;
          hit     = (rd_data_r.key == key_r);
        end
      end
      S_SHRD: begin
        if (op_r == skt_pkg::REQ_INSERT) begin
          if (sh_r == idx_r) begin
            mem_we       = 1'b1;
            mem_waddr    = idx_r[AW-1:0];
            mem_wdata.key    = key_r;
            mem_wdata.handle = hdl_r;
            state_nxt    = S_DONE;
          end else begin
            mem_raddr = AW'(sh_r - 1'b1);
            state_nxt = S_SHWR;
          end
        end else begin
          if (sh_r == cnt_r) begin
            state_nxt = S_DONE;
          end else begin
            mem_raddr = AW'(sh_r + 1'b1);
            state_nxt = S_SHWR;
          end
        end
      end
      S_SHWR: begin
        mem_we = 1'b1;
        if (op_r == skt_pkg::REQ_INSERT) begin
          sh_nxt = CW'(sh_r - 1'b1);
        end else begin
          sh_nxt = CW'(sh_r + 1'b1);
        end
        state_nxt = S_SHRD;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_cnt_nxt   = skt_pkg::COUNT_W'(cnt_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (resolve) begin
      state_nxt = S_DONE;
      case (op_r)
        skt_pkg::REQ_INSERT: begin
          if (hit) begin
            res_nxt.status = skt_pkg::ST_DUP;
          end else if (cnt_r == CAP_C) begin
            res_nxt.status = skt_pkg::ST_FULL;
          end else begin
            cnt_nxt   = CW'(cnt_r + 1'b1);
            cur_nxt   = '0;
            sh_nxt    = cnt_r;
            state_nxt = S_SHRD;
          end
        end
        skt_pkg::REQ_REMOVE: begin
          if (!hit) begin
            res_nxt.status = skt_pkg::ST_MISSING;
          end else begin
            cnt_nxt   = CW'(cnt_r - 1'b1);
            cur_nxt   = '0;
            sh_nxt    = idx_r;
            state_nxt = S_SHRD;
          end
        end
        skt_pkg::REQ_SEARCH: begin
          if (!hit) begin
            res_nxt.status = skt_pkg::ST_MISSING;
          end else begin
            res_nxt.entry = rd_data_r;
          end
        end
        default: begin
          state_nxt = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    hdl_r     <= hdl_nxt;
    idx_r     <= idx_nxt;
    sh_r      <= sh_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_key_out     = out_res_r.entry.key;
  assign out_handle_out  = out_res_r.entry.handle;
  assign out_entry_count = out_cnt_r;

  `SKT_ASSERT(a_cnt_cap, cnt_r <= CAP_C, "entry count above capacity")
  `SKT_ASSERT(a_cur_le_cnt, cur_r <= cnt_r, "cursor beyond stored entries")
  `SKT_ASSERT(a_we_state, !mem_we || state_r == S_SHRD || state_r == S_SHWR, "stray write")
  `SKT_ASSERT_NEXT(a_cnt_step, 1'b1,
    cnt_r == $past(cnt_r) || cnt_r == CW'($past(cnt_r) + 1'b1) ||
    CW'(cnt_r + 1'b1) == $past(cnt_r), "count moved by more than one")

endmodule
